// File: rtl/rx_ring_buffer_key_frame_extractor_defines.svh
// Assertion macros used by the top-level RTL file.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef RX_RING_BUFFER_KEY_FRAME_EXTRACTOR_DEFINES_SVH
`define RX_RING_BUFFER_KEY_FRAME_EXTRACTOR_DEFINES_SVH

`ifndef SYNTH

// Property holds at every clock edge outside reset
`define RXKF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rxkf assertion failed");

// Consequent holds in the same cycle as the antecedent
`define RXKF_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rxkf assertion failed");

// Consequent holds in the cycle after the antecedent
`define RXKF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rxkf assertion failed");

`else

`define RXKF_ASSERT(lbl, prop)
`define RXKF_ASSERT_IMPL(lbl, ante, cons)
`define RXKF_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/rxkf_pkg.sv
`timescale 1ns / 1ps

package rxkf_pkg;

    // Operation codes
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_POP  = 2'd1;
    localparam logic [1:0] OP_POLL = 2'd2;

    // Frame delimiters
    localparam logic [7:0] HEADER_BYTE  = 8'hAA;
    localparam logic [7:0] TRAILER_BYTE = 8'hFF;

    // Frame synchronizer states
    typedef enum logic [2:0] {
        SYNC_HEADER  = 3'b001,
        SYNC_KEY     = 3'b010,
        SYNC_TRAILER = 3'b100
    } sync_state_t;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_PROC = 3'b010,
        ST_DONE = 3'b100
    } seq_state_t;

    // Byte handed to the synchronizer
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } sync_in_t;

    // Synchronizer status
    typedef struct packed {
        logic       found;
        logic [7:0] key;
    } sync_out_t;

endpackage

// File: rtl/rxkf_frame_sync.sv
`timescale 1ns / 1ps

module rxkf_frame_sync
(
    input  logic                clk,
    input  logic                rst_n,
    input  rxkf_pkg::sync_in_t  sync_in,
    output rxkf_pkg::sync_out_t sync_out,
    output logic [15:0]         frame_count
);

    rxkf_pkg::sync_state_t state_reg;
    rxkf_pkg::sync_state_t state_next;
    logic [7:0]            pending_key_reg;
    logic [7:0]            pending_key_next;
    logic [15:0]           frame_count_reg;
    logic [15:0]           frame_count_next;
    logic                  found;

    // Advance the header / key / trailer search by one byte
    always_comb
    begin
        state_next       = state_reg;
        pending_key_next = pending_key_reg;
        frame_count_next = frame_count_reg;
        found            = 1'b0;
        if (sync_in.valid)
        begin
            case (state_reg)
                rxkf_pkg::SYNC_HEADER:
                begin
                    if (sync_in.data == rxkf_pkg::HEADER_BYTE)
                    begin
                        state_next = rxkf_pkg::SYNC_KEY;
                    end
                end
                rxkf_pkg::SYNC_KEY:
                begin
                    pending_key_next = sync_in.data;
                    state_next       = rxkf_pkg::SYNC_TRAILER;
                end
                rxkf_pkg::SYNC_TRAILER:
                begin
                    if (sync_in.data == rxkf_pkg::TRAILER_BYTE)
                    begin
                        found            = 1'b1;
                        frame_count_next = frame_count_reg + 16'd1;
                        state_next       = rxkf_pkg::SYNC_HEADER;
                    end
                    else if (sync_in.data == rxkf_pkg::HEADER_BYTE)
                    begin
                        // bad trailer that looks like a header restarts the frame
                        state_next = rxkf_pkg::SYNC_KEY;
                    end
                    else
                    begin
                        state_next = rxkf_pkg::SYNC_HEADER;
                    end
                end
                default:
                begin
                    state_next = rxkf_pkg::SYNC_HEADER;
                end
            endcase
        end
    end

    // Hold synchronizer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= rxkf_pkg::SYNC_HEADER;
            pending_key_reg <= 8'd0;
            frame_count_reg <= 16'd0;
        end
        else
        begin
            state_reg       <= state_next;
            pending_key_reg <= pending_key_next;
            frame_count_reg <= frame_count_next;
        end
    end

    assign sync_out.found = found;
    assign sync_out.key   = pending_key_reg;
    assign frame_count    = frame_count_reg;

endmodule

// File: rtl/rx_ring_buffer_key_frame_extractor.sv
`timescale 1ns / 1ps
// Receive byte ring buffer with a 0xAA KEY 0xFF key-frame extractor. Each transaction
// carries one operation: push stores byte_in (overwriting the oldest byte when full),
// pop returns the oldest byte, poll drains bytes until the first complete frame or
// until the buffer is empty. Bytes live in one synchronous RAM of BUFFER_DEPTH entries
// with a single registered read port; there is no clearing pass after reset.
// A push goes idle to done, a pop idle to process to done (idle to done when empty), and
// a poll stays in process while it drains, one byte per cycle through the RAM read port.
// A new operation is accepted while the previous result still waits at the output.

`include "rx_ring_buffer_key_frame_extractor_defines.svh"

module rx_ring_buffer_key_frame_extractor
#(
    parameter int BUFFER_DEPTH = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  opcode,
    input  logic [7:0]  byte_in,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  read_byte,
    output logic        read_valid,
    output logic [8:0]  fill_count,
    output logic        key_found,
    output logic [7:0]  key_value,
    output logic [15:0] frame_number
);

    localparam int PTR_W = $clog2(BUFFER_DEPTH);
    localparam int CNT_W = $clog2(BUFFER_DEPTH + 1);

    // Byte store
    logic [7:0]             mem [BUFFER_DEPTH];
    logic [7:0]             rd_data_reg;
    logic                   mem_we;
    logic                   mem_re;

    rxkf_pkg::seq_state_t   state_reg;
    rxkf_pkg::seq_state_t   state_next;
    logic [PTR_W-1:0]       wr_pos_reg;
    logic [PTR_W-1:0]       wr_pos_next;
    logic [PTR_W-1:0]       rd_pos_reg;
    logic [PTR_W-1:0]       rd_pos_next;
    logic [CNT_W-1:0]       held_count_reg;
    logic [CNT_W-1:0]       held_count_next;
    logic                   is_poll_reg;
    logic                   is_poll_next;

    logic [7:0]             res_byte_reg;
    logic [7:0]             res_byte_next;
    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic                   res_found_reg;
    logic                   res_found_next;
    logic [7:0]             res_key_reg;
    logic [7:0]             res_key_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [7:0]             out_byte_reg;
    logic [7:0]             out_byte_next;
    logic                   out_rvalid_reg;
    logic                   out_rvalid_next;
    logic [8:0]             out_fill_reg;
    logic [8:0]             out_fill_next;
    logic                   out_found_reg;
    logic                   out_found_next;
    logic [7:0]             out_key_reg;
    logic [7:0]             out_key_next;
    logic [15:0]            out_frame_reg;
    logic [15:0]            out_frame_next;

    logic                   in_accept;
    logic                   out_load;
    logic                   buf_full;
    logic                   buf_empty;
    rxkf_pkg::sync_in_t     sync_in;
    rxkf_pkg::sync_out_t    sync_out;
    logic [15:0]            frame_count;

    // Step a ring position with wrap at the buffer depth
    function automatic logic [PTR_W-1:0] pos_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(BUFFER_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    rxkf_frame_sync u_sync
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .sync_in     (sync_in),
        .sync_out    (sync_out),
        .frame_count (frame_count)
    );

    assign in_stall  = (state_reg != rxkf_pkg::ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_load  = (state_reg == rxkf_pkg::ST_DONE) && (!out_valid_reg || !out_stall);
    assign buf_full  = (held_count_reg == CNT_W'(BUFFER_DEPTH));
    assign buf_empty = (held_count_reg == '0);

    // Sequence operations over the byte store
    always_comb
    begin
        state_next      = state_reg;
        wr_pos_next     = wr_pos_reg;
        rd_pos_next     = rd_pos_reg;
        held_count_next = held_count_reg;
        is_poll_next    = is_poll_reg;
        res_byte_next   = res_byte_reg;
        res_valid_next  = res_valid_reg;
        res_found_next  = res_found_reg;
        res_key_next    = res_key_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_byte_next   = out_byte_reg;
        out_rvalid_next = out_rvalid_reg;
        out_fill_next   = out_fill_reg;
        out_found_next  = out_found_reg;
        out_key_next    = out_key_reg;
        out_frame_next  = out_frame_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        sync_in.valid   = 1'b0;
        sync_in.data    = rd_data_reg;

        case (state_reg)
            rxkf_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    res_byte_next  = 8'd0;
                    res_valid_next = 1'b0;
                    res_found_next = 1'b0;
                    res_key_next   = 8'd0;
                    state_next     = rxkf_pkg::ST_DONE;
                    case (opcode)
                        rxkf_pkg::OP_PUSH:
                        begin
                            // store; drop the oldest byte when full
                            mem_we      = 1'b1;
                            wr_pos_next = pos_inc(wr_pos_reg);
                            if (buf_full)
                            begin
                                rd_pos_next = pos_inc(rd_pos_reg);
                            end
                            else
                            begin
                                held_count_next = held_count_reg + CNT_W'(1);
                            end
                        end
                        rxkf_pkg::OP_POP, rxkf_pkg::OP_POLL:
                        begin
                            is_poll_next = (opcode == rxkf_pkg::OP_POLL);
                            if (!buf_empty)
                            begin
                                mem_re          = 1'b1;
                                rd_pos_next     = pos_inc(rd_pos_reg);
                                held_count_next = held_count_reg - CNT_W'(1);
                                state_next      = rxkf_pkg::ST_PROC;
                            end
                        end
                        default:
                        begin
                            state_next = rxkf_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            rxkf_pkg::ST_PROC:
            begin
                if (!is_poll_reg)
                begin
                    res_byte_next  = rd_data_reg;
                    res_valid_next = 1'b1;
                    state_next     = rxkf_pkg::ST_DONE;
                end
                else
                begin
                    // feed the byte to the synchronizer; fetch the next unless done
                    sync_in.valid = 1'b1;
                    if (sync_out.found)
                    begin
                        res_found_next = 1'b1;
                        res_key_next   = sync_out.key;
                        state_next     = rxkf_pkg::ST_DONE;
                    end
                    else if (!buf_empty)
                    begin
                        mem_re          = 1'b1;
                        rd_pos_next     = pos_inc(rd_pos_reg);
                        held_count_next = held_count_reg - CNT_W'(1);
                    end
                    else
                    begin
                        state_next = rxkf_pkg::ST_DONE;
                    end
                end
            end
            rxkf_pkg::ST_DONE:
            begin
                // load the result once the output register is free
                if (out_load)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = res_byte_reg;
                    out_rvalid_next = res_valid_reg;
                    out_fill_next   = 9'(held_count_reg);
                    out_found_next  = res_found_reg;
                    out_key_next    = res_key_reg;
                    out_frame_next  = frame_count;
                    state_next      = rxkf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rxkf_pkg::ST_IDLE;
            end
        endcase
    end

    // Write and read the byte store
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_pos_reg] <= byte_in;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_pos_reg];
        end
    end

    // Hold control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rxkf_pkg::ST_IDLE;
            wr_pos_reg     <= '0;
            rd_pos_reg     <= '0;
            held_count_reg <= '0;
            is_poll_reg    <= 1'b0;
            res_byte_reg   <= 8'd0;
            res_valid_reg  <= 1'b0;
            res_found_reg  <= 1'b0;
            res_key_reg    <= 8'd0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= 8'd0;
            out_rvalid_reg <= 1'b0;
            out_fill_reg   <= 9'd0;
            out_found_reg  <= 1'b0;
            out_key_reg    <= 8'd0;
            out_frame_reg  <= 16'd0;
        end
        else
        begin
            state_reg      <= state_next;
            wr_pos_reg     <= wr_pos_next;
            rd_pos_reg     <= rd_pos_next;
            held_count_reg <= held_count_next;
            is_poll_reg    <= is_poll_next;
            res_byte_reg   <= res_byte_next;
            res_valid_reg  <= res_valid_next;
            res_found_reg  <= res_found_next;
            res_key_reg    <= res_key_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_rvalid_reg <= out_rvalid_next;
            out_fill_reg   <= out_fill_next;
            out_found_reg  <= out_found_next;
            out_key_reg    <= out_key_next;
            out_frame_reg  <= out_frame_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign read_byte    = out_byte_reg;
    assign read_valid   = out_rvalid_reg;
    assign fill_count   = out_fill_reg;
    assign key_found    = out_found_reg;
    assign key_value    = out_key_reg;
    assign frame_number = out_frame_reg;

    `RXKF_ASSERT(a_count_max, held_count_reg <= CNT_W'(BUFFER_DEPTH))
    `RXKF_ASSERT(a_no_rw_overlap, !(mem_we && mem_re))
    `RXKF_ASSERT_IMPL(a_proc_after_read, state_reg == rxkf_pkg::ST_PROC, $past(mem_re))
    `RXKF_ASSERT_NEXT(a_full_push_keeps, in_accept && (opcode == rxkf_pkg::OP_PUSH) && buf_full, buf_full)

endmodule
